// File: hdl/positional_list_store_unit_assert.svh
// Assertion helpers for the positional list store.
`ifndef POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PLSU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/plsu_pkg.sv
package plsu_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 7;
  localparam int LEN_W  = 7;
  localparam int ST_W   = 2;
  localparam int REQ_W  = 3;
  localparam int GRP    = 8;

  localparam logic [REQ_W-1:0] REQ_READ     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INSERT   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_APPEND   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PREPEND  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd5;
  localparam logic [REQ_W-1:0] REQ_TRUNCATE = 3'd6;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd7;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_OPEN  = 3'd3;
  localparam logic [2:0] CMD_CLOSE = 3'd4;

  typedef struct packed {
    logic [2:0]        op;
    logic [DATA_W-1:0] data;
  } cell_cmd_t;

endpackage

// File: hdl/positional_list_store_unit.sv
// Ordered list of up to DEPTH signed 32-bit words held in a row of cells.
// Each request (read, write, insert before, append, prepend, remove,
// truncate, clear) returns one result: the word read, the new length and
// a status. One request is in flight at a time: the cycle after a request
// is accepted, every cell updates at once (an insert or remove shifts the
// whole row) and the masked read words of each group of eight cells are
// OR-ed into a register; once the output register is free or being taken,
// the group results are combined into it. The next request is accepted
// only after that; a stalled output holds the block after the result has
// been formed.
// The row needs no clearing after reset: entries at or beyond the length
// are never read.
module positional_list_store_unit import plsu_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // position[6:0], data_value[38:7], zero[39]
  input  logic [2:0]  in_tuser,  // req_type[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata  // read_value[31:0], list_length[38:32], status[40:39]
);

  localparam int CW_MIN = $clog2(DEPTH + 1);
  localparam int CW     = (CW_MIN > POS_W) ? CW_MIN : POS_W;
  localparam int NGRP   = (DEPTH + GRP - 1) / GRP;
  localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);

  logic              req_v_r;
  logic [REQ_W-1:0]  req_type_r;
  logic [POS_W-1:0]  req_pos_r;
  logic [DATA_W-1:0] req_data_r;

  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic [ST_W-1:0]   st_nxt;
  logic [2:0]        op_nxt;
  logic [CW-1:0]     at_nxt;

  logic              grp_v_r;
  logic [CW-1:0]     len_r;
  logic [ST_W-1:0]   st_r;

  logic              out_v_r;
  logic [DATA_W-1:0] out_rd_r;
  logic [LEN_W-1:0]  out_len_r;
  logic [ST_W-1:0]   out_st_r;

  logic [CW-1:0]     pos_w;
  logic              pos_ok;
  logic              full;
  logic              in_fire;
  logic              out_load;

  cell_cmd_t         cmd;
  logic [DATA_W-1:0] cell_q  [DEPTH];
  logic [DATA_W-1:0] cell_rd [NGRP*GRP];
  logic [DATA_W-1:0] grp_q   [NGRP];
  logic [DATA_W-1:0] rd_all;

  assign in_tready = !req_v_r && !grp_v_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = grp_v_r && (!out_v_r || out_tready);

  assign pos_w  = CW'(req_pos_r);
  assign pos_ok = pos_w < cnt_r;
  assign full   = cnt_r >= DEPTH_CW;

  always_comb begin
    cnt_nxt = cnt_r;
    st_nxt  = ST_DONE;
    op_nxt  = CMD_NONE;
    at_nxt  = pos_w;
    case (req_type_r)
      REQ_READ: begin
        if (pos_ok) op_nxt = CMD_READ;
        else st_nxt = ST_RANGE;
      end
      REQ_WRITE: begin
        if (pos_ok) op_nxt = CMD_WRITE;
        else st_nxt = ST_RANGE;
      end
      REQ_INSERT: begin
        if (!pos_ok) st_nxt = ST_RANGE;
        else if (full) st_nxt = ST_FULL;
        else begin
          op_nxt  = CMD_OPEN;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      REQ_APPEND: begin
        at_nxt = cnt_r;
        if (full) st_nxt = ST_FULL;
        else begin
          op_nxt  = CMD_OPEN;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      REQ_PREPEND: begin
        at_nxt = '0;
        if (full) st_nxt = ST_FULL;
        else begin
          op_nxt  = CMD_OPEN;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      REQ_REMOVE: begin
        if (pos_ok) begin
          op_nxt  = CMD_CLOSE;
          cnt_nxt = cnt_r - CW'(1);
        end else st_nxt = ST_RANGE;
      end
      REQ_TRUNCATE: begin
        if (pos_w <= cnt_r) cnt_nxt = pos_w;
        else st_nxt = ST_RANGE;
      end
      REQ_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  assign cmd.op   = req_v_r ? op_nxt : CMD_NONE;
  assign cmd.data = req_data_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] prev_w;
    logic [DATA_W-1:0] next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_prev
      assign prev_w = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_next
      assign next_w = cell_q[i+1];
    end
    plsu_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk    (clk),
      .cmd    (cmd),
      .at     (at_nxt),
      .prev_q (prev_w),
      .next_q (next_w),
      .q      (cell_q[i]),
      .rd     (cell_rd[i])
    );
  end

  for (genvar i = DEPTH; i < NGRP*GRP; i++) begin : g_pad
    assign cell_rd[i] = '0;
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    plsu_rdgrp u_grp (
      .clk  (clk),
      .load (req_v_r),
      .rd_i (cell_rd[g*GRP +: GRP]),
      .q    (grp_q[g])
    );
  end

  always_comb begin
    rd_all = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_all = rd_all | grp_q[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
      grp_v_r <= 1'b0;
      out_v_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (in_fire) req_v_r <= 1'b1;
      else if (req_v_r) req_v_r <= 1'b0;
      if (req_v_r) begin
        grp_v_r <= 1'b1;
        cnt_r   <= cnt_nxt;
      end else if (out_load) begin
        grp_v_r <= 1'b0;
      end
      if (out_load) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_type_r <= in_tuser;
      req_pos_r  <= in_tdata[POS_W-1:0];
      req_data_r <= in_tdata[POS_W +: DATA_W];
    end
    if (req_v_r) begin
      len_r <= cnt_nxt;
      st_r  <= st_nxt;
    end
    if (out_load) begin
      out_rd_r  <= rd_all;
      out_len_r <= LEN_W'(len_r);
      out_st_r  <= st_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_st_r, out_len_r, out_rd_r};

`include "positional_list_store_unit_assert.svh"

  `PLSU_ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= DEPTH_CW, "length above depth")
  `PLSU_ASSERT_IMPL(a_one_busy, clk, rst_n, 1'b1, $onehot0({req_v_r, grp_v_r}), "two stages busy")
  `PLSU_ASSERT_NEXT(a_fail_keep, clk, rst_n, req_v_r && st_nxt != ST_DONE, cnt_r == $past(cnt_r), "failed request changed length")
  `PLSU_ASSERT_NEXT(a_len_match, clk, rst_n, req_v_r, len_r == cnt_r, "result length differs from stored length")

endmodule

// File: hdl/plsu_cell.sv
module plsu_cell import plsu_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [CW-1:0]     at,
  input  logic [DATA_W-1:0] prev_q,
  input  logic [DATA_W-1:0] next_q,
  output logic [DATA_W-1:0] q,
  output logic [DATA_W-1:0] rd
);

  localparam logic [CW-1:0] MY = CW'(IDX);

  logic [DATA_W-1:0] q_r;
  logic [DATA_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    case (cmd.op)
      CMD_WRITE: begin
        if (MY == at) q_nxt = cmd.data;
      end
      CMD_OPEN: begin
        if (MY > at) q_nxt = prev_q;
        else if (MY == at) q_nxt = cmd.data;
      end
      CMD_CLOSE: begin
        if (MY >= at) q_nxt = next_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q  = q_r;
  assign rd = (cmd.op == CMD_READ && MY == at) ? q_r : '0;

endmodule

// File: hdl/plsu_rdgrp.sv
module plsu_rdgrp import plsu_pkg::*; (
  input  logic              clk,
  input  logic              load,
  input  logic [DATA_W-1:0] rd_i [GRP],
  output logic [DATA_W-1:0] q
);

  logic [DATA_W-1:0] q_r;
  logic [DATA_W-1:0] q_nxt;

  always_comb begin
    q_nxt = '0;
    for (int k = 0; k < GRP; k++) begin
      q_nxt = q_nxt | rd_i[k];
    end
  end

  always_ff @(posedge clk) begin
    if (load) q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// File: tb/positional_list_store_unit_test.sv
`timescale 1ns / 100ps

module positional_list_store_unit_test;
  import plsu_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int RANDOM_REQS = 1000;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    logic [31:0] word;
    logic [6:0]  len;
    logic [1:0]  status;
  } list_result_t;

  // mirror of the list; expected results in request order
  class list_scoreboard;
    logic [31:0]  cells [LIST_DEPTH];
    int           count;
    list_result_t awaiting [$];
    int           mismatches;
    int           results_seen;
    int           kind_seen [8];
    int           range_hits;
    int           full_hits;
    int           peak_len;

    function new();
      count = 0;
      mismatches = 0;
      results_seen = 0;
      range_hits = 0;
      full_hits = 0;
      peak_len = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void open_gap(int at, logic [31:0] value);
      for (int i = count; i > at; i--) cells[i] = cells[i-1];
      cells[at] = value;
      count++;
    endfunction

    function void close_gap(int at);
      for (int i = at; i < count - 1; i++) cells[i] = cells[i+1];
      count--;
    endfunction

    function void note_request(logic [2:0] kind, logic [6:0] pos, logic [31:0] data);
      list_result_t r;
      bit in_range;
      bit full;
      r.word = '0;
      r.status = ST_DONE;
      in_range = pos < count;
      full = count >= LIST_DEPTH;
      kind_seen[kind]++;
      case (kind)
        REQ_READ: begin
          if (in_range) r.word = cells[pos];
          else r.status = ST_RANGE;
        end
        REQ_WRITE: begin
          if (in_range) cells[pos] = data;
          else r.status = ST_RANGE;
        end
        REQ_INSERT: begin
          if (!in_range) r.status = ST_RANGE;
          else if (full) r.status = ST_FULL;
          else open_gap(pos, data);
        end
        REQ_APPEND: begin
          if (full) r.status = ST_FULL;
          else open_gap(count, data);
        end
        REQ_PREPEND: begin
          if (full) r.status = ST_FULL;
          else open_gap(0, data);
        end
        REQ_REMOVE: begin
          if (in_range) close_gap(pos);
          else r.status = ST_RANGE;
        end
        REQ_TRUNCATE: begin
          if (pos <= count) count = pos;
          else r.status = ST_RANGE;
        end
        default: count = 0;
      endcase
      if (r.status == ST_RANGE) range_hits++;
      if (r.status == ST_FULL) full_hits++;
      if (count > peak_len) peak_len = count;
      r.len = count[6:0];
      awaiting.push_back(r);
    endfunction

    function void check_result(logic [47:0] tdata);
      list_result_t want;
      logic [31:0] got_word;
      logic [6:0]  got_len;
      logic [1:0]  got_status;
      got_word = tdata[31:0];
      got_len = tdata[38:32];
      got_status = tdata[40:39];
      results_seen++;
      if (awaiting.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: word=%h len=%0d status=%0d",
                   $time, got_word, got_len, got_status);
        return;
      end
      want = awaiting.pop_front();
      if (got_word !== want.word || got_len !== want.len || got_status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch #%0d: word exp %h got %h, len exp %0d got %0d, status exp %0d got %0d",
                   $time, results_seen, want.word, got_word, want.len, got_len,
                   want.status, got_status);
      end
    endfunction

    function int pending();
      return awaiting.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  list_scoreboard sb = new();
  int cycles = 0;
  int sent = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  logic [2:0] req_order [8] = '{REQ_READ, REQ_WRITE, REQ_INSERT, REQ_APPEND,
                                REQ_PREPEND, REQ_REMOVE, REQ_TRUNCATE, REQ_CLEAR};
  // weights per episode flavor: growing, shrinking, mixed
  int req_weight [3][8] = '{'{10, 10, 25, 25, 20, 7, 2, 1},
                            '{15, 10, 8, 8, 5, 40, 12, 2},
                            '{25, 20, 13, 12, 10, 15, 4, 1}};

  positional_list_store_unit #(.DEPTH(LIST_DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("FAIL");
      $finish;
    end
  end

  // result side: check accepted transactions, stall in changing patterns
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (mode_left == 0) begin
      mode_left <= $urandom_range(16, 200);
      stall_mode <= $urandom_range(0, 2);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_req(logic [2:0] kind, logic [6:0] pos, logic [31:0] data);
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, data, pos};
    in_tuser <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(kind, pos, data);
    sent++;
  endtask

  task automatic sender_gap();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 30);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [2:0] pick_kind(int flavor);
    int r;
    r = $urandom_range(0, 99);
    for (int i = 0; i < 8; i++) begin
      if (r < req_weight[flavor][i]) return req_order[i];
      r -= req_weight[flavor][i];
    end
    return REQ_READ;
  endfunction

  function automatic logic [6:0] pick_pos(logic [2:0] kind);
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = sb.count;
    if (kind == REQ_TRUNCATE) begin
      if (r < 80) return 7'($urandom_range(0, n));
      return 7'($urandom_range(0, LIST_DEPTH));
    end
    if (r < 75 && n > 0) return 7'($urandom_range(0, n - 1));
    if (r < 90) begin
      case ($urandom_range(0, 3))
        0: return 7'd0;
        1: return 7'(n);
        2: return (n > 0) ? 7'(n - 1) : 7'd0;
        default: return 7'(LIST_DEPTH);
      endcase
    end
    return 7'($urandom_range(0, LIST_DEPTH));
  endfunction

  function automatic logic [31:0] pick_data();
    if ($urandom_range(0, 6) != 0) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  initial begin
    int flavor;
    int episode_len;
    logic [2:0] kind;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty list corner cases
    send_req(REQ_READ, 7'd0, 32'h1234_5678);
    send_req(REQ_INSERT, 7'd0, 32'h1111_1111);
    send_req(REQ_REMOVE, 7'd0, '0);
    send_req(REQ_WRITE, 7'd0, 32'hDEAD_BEEF);
    send_req(REQ_TRUNCATE, 7'd1, '0);
    send_req(REQ_TRUNCATE, 7'd0, '0);
    // build a short list with extreme words
    send_req(REQ_APPEND, 7'd64, 32'h7FFF_FFFF);
    send_req(REQ_APPEND, 7'd0, 32'h8000_0000);
    send_req(REQ_PREPEND, 7'd0, 32'hFFFF_FFFF);
    send_req(REQ_INSERT, 7'd1, 32'h0000_0000);
    send_req(REQ_INSERT, 7'd3, 32'h0000_0001);
    send_req(REQ_INSERT, 7'd5, 32'h5555_AAAA);
    send_req(REQ_READ, 7'd0, '0);
    send_req(REQ_READ, 7'd4, '0);
    send_req(REQ_READ, 7'd5, '0);
    send_req(REQ_WRITE, 7'd2, 32'hA5A5_5A5A);
    send_req(REQ_WRITE, 7'd64, 32'h0F0F_0F0F);
    send_req(REQ_REMOVE, 7'd1, '0);
    send_req(REQ_REMOVE, 7'd3, '0);
    send_req(REQ_READ, 7'd1, '0);
    send_req(REQ_TRUNCATE, 7'(sb.count), '0);
    send_req(REQ_TRUNCATE, 7'd64, '0);
    send_req(REQ_CLEAR, 7'd64, 32'hFFFF_FFFF);
    send_req(REQ_READ, 7'd0, '0);

    // random episodes, each leaning toward growth, shrinkage or churn
    while (sent < RANDOM_REQS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: flavor = 0;
        8, 9, 10, 11, 12: flavor = 1;
        default: flavor = 2;
      endcase
      episode_len = $urandom_range(20, 150);
      repeat (episode_len) begin
        if (sent >= RANDOM_REQS) break;
        sender_gap();
        kind = pick_kind(flavor);
        send_req(kind, pick_pos(kind), pick_data());
      end
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d requests (rd %0d wr %0d ins %0d app %0d pre %0d rem %0d trunc %0d clr %0d)",
             sent, sb.kind_seen[REQ_READ], sb.kind_seen[REQ_WRITE],
             sb.kind_seen[REQ_INSERT], sb.kind_seen[REQ_APPEND],
             sb.kind_seen[REQ_PREPEND], sb.kind_seen[REQ_REMOVE],
             sb.kind_seen[REQ_TRUNCATE], sb.kind_seen[REQ_CLEAR]);
    $display("%0d results checked, %0d out of range, %0d store full, peak length %0d, %0d mismatches",
             sb.results_seen, sb.range_hits, sb.full_hits, sb.peak_len, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: positional_list_store_unit.f
+incdir+hdl
hdl/plsu_pkg.sv
hdl/plsu_cell.sv
hdl/plsu_rdgrp.sv
hdl/positional_list_store_unit.sv
tb/positional_list_store_unit_test.sv
